// File: hw/rtl/apct_pkg.sv
package apct_pkg;

  localparam int SLOT_W    = 5;
  localparam int COORD_W   = 16;
  localparam int SIZE_W    = 15;
  localparam int KIND_W    = 4;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 3;
  localparam int MASK_REGS = 4;
  localparam int MASK_W    = 64;
  localparam int MAX_PAIRS = 31;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCAN   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_ADDED   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_REMOVED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_PAIR    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NONE    = 3'd4;

  typedef struct packed {
    logic                      listens;
    logic [KIND_W-1:0]         kind;
    logic [SIZE_W-1:0]         h;
    logic [SIZE_W-1:0]         w;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic notify_a;
    logic notify_b;
  } pair_t;

  typedef logic [MASK_REGS-1:0][MASK_W-1:0] mask_t;

  function automatic logic mask_bit(mask_t m, logic [KIND_W-1:0] row,
                                    logic [KIND_W-1:0] col);
    return m[row[3:2]][{row[1:0], col}];
  endfunction

endpackage

// File: hw/rtl/apct_slot_mem.sv
module apct_slot_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  apct_pkg::entry_t  wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output apct_pkg::entry_t  rdata
);

  apct_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/apct_pair_check.sv
module apct_pair_check (
  input  apct_pkg::entry_t a_ent,
  input  apct_pkg::entry_t b_ent,
  input  logic             b_valid,
  input  apct_pkg::mask_t  mask,
  output apct_pkg::pair_t  res
);

  logic signed [16:0] ax, ay, bx, by;
  logic signed [16:0] ax_end, ay_end, bx_end, by_end;
  logic               overlap;
  logic               na, nb;

  assign ax = {a_ent.x[15], a_ent.x};
  assign ay = {a_ent.y[15], a_ent.y};
  assign bx = {b_ent.x[15], b_ent.x};
  assign by = {b_ent.y[15], b_ent.y};

  assign ax_end = ax + $signed({2'b00, a_ent.w});
  assign ay_end = ay + $signed({2'b00, a_ent.h});
  assign bx_end = bx + $signed({2'b00, b_ent.w});
  assign by_end = by + $signed({2'b00, b_ent.h});

  assign overlap = (ax < bx_end) && (ax_end > bx) && (ay < by_end) && (ay_end > by);

  assign na = apct_pkg::mask_bit(mask, a_ent.kind, b_ent.kind) & a_ent.listens;
  assign nb = apct_pkg::mask_bit(mask, b_ent.kind, a_ent.kind) & b_ent.listens;

  assign res.hit      = b_valid & overlap & (na | nb);
  assign res.notify_a = na;
  assign res.notify_b = nb;

endmodule

// File: hw/rtl/aabb_pair_collision_table.sv
// Channel  Dir  Handshake              Payload
// in       in   in_tvalid/in_tready    tuser command, tdata slot and new collider
// out      out  out_tvalid/out_tready  tuser status, tdata slots and notify flags, tlast
// cfg      in   cfg_we                 cfg_addr selects one of four pair mask words
//
// A scan of slot s reads one table entry per cycle from the slot memory, except while a held
// pair is waiting for the output register to empty.
// Reset clears the valid bits and the pair mask at once; there is no clearing pass.
// A found pair is held until the next one (or the end of the scan) decides its tlast,
// and the scan pauses only while that held pair must be pushed and the output register is full.
module aabb_pair_collision_table #(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // slot, rect_x, rect_y, rect_w, rect_h, kind, listens
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // slot_a, slot_b, notify_a, notify_b, zero fill
  output logic [2:0]  out_tuser,  // status
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  apct_pkg::mask_t   mask_r;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [4:0]        pend_b_r, pend_b_nxt;
  logic              pend_na_r, pend_na_nxt;
  logic              pend_nb_r, pend_nb_nxt;
  logic [4:0]        scan_slot_r, scan_slot_nxt;
  apct_pkg::entry_t  a_ent_r, a_ent_nxt;

  logic              out_valid_r;
  logic [2:0]        out_stat_r;
  logic [4:0]        out_a_r, out_b_r;
  logic              out_na_r, out_nb_r, out_last_r;

  logic              push, push_na, push_nb, push_last;
  logic [2:0]        push_stat;
  logic [4:0]        push_a, push_b;

  logic              can_push, in_fire, in_range;
  logic [1:0]        in_cmd;
  logic [4:0]        in_slot;
  logic [IW-1:0]     slot_idx;
  apct_pkg::entry_t  new_ent;
  logic              free_found;
  logic [IW-1:0]     free_idx;

  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_raddr;
  apct_pkg::entry_t  mem_rdata;
  apct_pkg::pair_t   pair_res;

  assign in_cmd          = in_tuser;
  assign in_slot         = in_tdata[4:0];
  assign new_ent.x       = in_tdata[20:5];
  assign new_ent.y       = in_tdata[36:21];
  assign new_ent.w       = in_tdata[51:37];
  assign new_ent.h       = in_tdata[66:52];
  assign new_ent.kind    = in_tdata[70:67];
  assign new_ent.listens = in_tdata[71];

  assign slot_idx = IW'(in_slot);
  assign in_range = int'(in_slot) < SLOTS;

  assign can_push  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && can_push;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  apct_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (free_idx),
    .wdata (new_ent),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  apct_pair_check u_check (
    .a_ent   (a_ent_r),
    .b_ent   (mem_rdata),
    .b_valid (valid_r[cmp_idx_r]),
    .mask    (mask_r),
    .res     (pair_res)
  );

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_b_nxt    = pend_b_r;
    pend_na_nxt   = pend_na_r;
    pend_nb_nxt   = pend_nb_r;
    scan_slot_nxt = scan_slot_r;
    a_ent_nxt     = a_ent_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    push          = 1'b0;
    push_stat     = apct_pkg::STAT_NONE;
    push_a        = '0;
    push_b        = '0;
    push_na       = 1'b0;
    push_nb       = 1'b0;
    push_last     = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            apct_pkg::CMD_ADD: begin
              push = 1'b1;
              if (free_found) begin
                mem_we              = 1'b1;
                valid_nxt[free_idx] = 1'b1;
                push_stat           = apct_pkg::STAT_ADDED;
                push_a              = 5'(free_idx);
              end else begin
                push_stat = apct_pkg::STAT_FULL;
              end
            end
            apct_pkg::CMD_REMOVE: begin
              if (in_range) begin
                valid_nxt[slot_idx] = 1'b0;
              end
              push      = 1'b1;
              push_stat = apct_pkg::STAT_REMOVED;
              push_a    = in_slot;
            end
            apct_pkg::CMD_SCAN: begin
              scan_slot_nxt = in_slot;
              if (in_range && valid_r[slot_idx]) begin
                mem_re    = 1'b1;
                mem_raddr = slot_idx;
                idx_nxt   = CW'(slot_idx) + CW'(1);
                cnt_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = ST_LOAD;
              end else begin
                push      = 1'b1;
                push_stat = apct_pkg::STAT_NONE;
                push_a    = in_slot;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        a_ent_nxt = mem_rdata;
        if (idx_r == CW'(SLOTS)) begin
          state_nxt = ST_FLUSH;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = idx_r[IW-1:0];
          cmp_idx_nxt = idx_r[IW-1:0];
          idx_nxt     = idx_r + CW'(1);
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!(pair_res.hit && pend_r && !can_push)) begin
          if (pair_res.hit) begin
            if (pend_r) begin
              push      = 1'b1;
              push_stat = apct_pkg::STAT_PAIR;
              push_a    = scan_slot_r;
              push_b    = pend_b_r;
              push_na   = pend_na_r;
              push_nb   = pend_nb_r;
              push_last = 1'b0;
            end
            pend_nxt    = 1'b1;
            pend_b_nxt  = 5'(cmp_idx_r);
            pend_na_nxt = pair_res.notify_a;
            pend_nb_nxt = pair_res.notify_b;
            cnt_nxt     = cnt_r + 5'd1;
          end
          if ((pair_res.hit && cnt_r == 5'(apct_pkg::MAX_PAIRS - 1)) ||
              idx_r == CW'(SLOTS)) begin
            state_nxt = ST_FLUSH;
          end else begin
            mem_re      = 1'b1;
            mem_raddr   = idx_r[IW-1:0];
            cmp_idx_nxt = idx_r[IW-1:0];
            idx_nxt     = idx_r + CW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          push      = 1'b1;
          push_a    = scan_slot_r;
          if (pend_r) begin
            push_stat = apct_pkg::STAT_PAIR;
            push_b    = pend_b_r;
            push_na   = pend_na_r;
            push_nb   = pend_nb_r;
          end else begin
            push_stat = apct_pkg::STAT_NONE;
          end
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        mask_r[cfg_addr] <= cfg_wdata;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    pend_b_r    <= pend_b_nxt;
    pend_na_r   <= pend_na_nxt;
    pend_nb_r   <= pend_nb_nxt;
    scan_slot_r <= scan_slot_nxt;
    a_ent_r     <= a_ent_nxt;
    if (push) begin
      out_stat_r <= push_stat;
      out_a_r    <= push_a;
      out_b_r    <= push_b;
      out_na_r   <= push_na;
      out_nb_r   <= push_nb;
      out_last_r <= push_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_nb_r, out_na_r, out_b_r, out_a_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

endmodule

// File: sim/tb_aabb_pair_collision_table.sv
module tb_aabb_pair_collision_table;

  localparam int TABLE_SLOTS = 32;
  localparam logic [apct_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [apct_pkg::CMD_W-1:0]          cmd;
    logic [apct_pkg::SLOT_W-1:0]         slot;
    logic signed [apct_pkg::COORD_W-1:0] x;
    logic signed [apct_pkg::COORD_W-1:0] y;
    logic [apct_pkg::SIZE_W-1:0]         w;
    logic [apct_pkg::SIZE_W-1:0]         h;
    logic [apct_pkg::KIND_W-1:0]         kind;
    logic                                listens;
  } cmd_beat_t;

  typedef struct packed {
    logic [apct_pkg::STAT_W-1:0] status;
    logic [apct_pkg::SLOT_W-1:0] slot_a;
    logic [apct_pkg::SLOT_W-1:0] slot_b;
    logic                        notify_a;
    logic                        notify_b;
    logic                        last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // slot, rect_x, rect_y, rect_w, rect_h, kind, listens
  logic [1:0]  in_tuser = '0;   // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // slot_a, slot_b, notify_a, notify_b, zero fill
  logic [2:0]  out_tuser;       // status
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [63:0] cfg_wdata = '0;

  aabb_pair_collision_table #(
    .SLOTS(TABLE_SLOTS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  cmd_beat_t        pending_beats[$];
  report_t          expected_reports[$];
  cmd_beat_t        offered_beat = '0;
  logic             slot_live [TABLE_SLOTS] = '{default: 1'b0};
  apct_pkg::entry_t slot_store [TABLE_SLOTS];
  logic [63:0]      mask_words [apct_pkg::MASK_REGS] = '{default: '0};
  int               issued_total = 0;
  int               accepted_total = 0;
  int               error_count = 0;
  int               idle_pct = 0;
  int               in_gap = 0;
  int               out_gap = 0;
  logic             hold_off = 1'b0;
  logic             offering;
  logic             taking;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic pair_enabled(logic [apct_pkg::KIND_W-1:0] row,
                                        logic [apct_pkg::KIND_W-1:0] col);
    return mask_words[row / 4][(row % 4) * 16 + col];
  endfunction

  function automatic logic rects_overlap(apct_pkg::entry_t a, apct_pkg::entry_t b);
    int ax, ay, aw, ah, bx, by, bw, bh;
    ax = int'(a.x);
    ay = int'(a.y);
    aw = int'(a.w);
    ah = int'(a.h);
    bx = int'(b.x);
    by = int'(b.y);
    bw = int'(b.w);
    bh = int'(b.h);
    return (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
  endfunction

  task automatic predict_reports(cmd_beat_t c);
    report_t r;
    report_t found[$];
    int i;
    logic [apct_pkg::KIND_W-1:0] ka, kb;
    logic na, nb;
    r = '0;
    r.last = 1'b1;
    case (c.cmd)
      apct_pkg::CMD_ADD: begin
        r.status = apct_pkg::STAT_FULL;
        for (i = 0; i < TABLE_SLOTS; i++) begin
          if (!slot_live[i]) begin
            slot_live[i] = 1'b1;
            slot_store[i].x = c.x;
            slot_store[i].y = c.y;
            slot_store[i].w = c.w;
            slot_store[i].h = c.h;
            slot_store[i].kind = c.kind;
            slot_store[i].listens = c.listens;
            r.status = apct_pkg::STAT_ADDED;
            r.slot_a = 5'(i);
            break;
          end
        end
        expected_reports.push_back(r);
      end
      apct_pkg::CMD_REMOVE: begin
        slot_live[c.slot] = 1'b0;
        r.status = apct_pkg::STAT_REMOVED;
        r.slot_a = c.slot;
        expected_reports.push_back(r);
      end
      apct_pkg::CMD_SCAN: begin
        if (slot_live[c.slot]) begin
          ka = slot_store[c.slot].kind;
          for (i = c.slot + 1; i < TABLE_SLOTS && found.size() < apct_pkg::MAX_PAIRS;
               i++) begin
            if (slot_live[i] && rects_overlap(slot_store[c.slot], slot_store[i])) begin
              kb = slot_store[i].kind;
              na = pair_enabled(ka, kb) && slot_store[c.slot].listens;
              nb = pair_enabled(kb, ka) && slot_store[i].listens;
              if (na || nb) begin
                r.status = apct_pkg::STAT_PAIR;
                r.slot_a = c.slot;
                r.slot_b = 5'(i);
                r.notify_a = na;
                r.notify_b = nb;
                r.last = 1'b0;
                found.push_back(r);
              end
            end
          end
        end
        if (found.size() == 0) begin
          r = '0;
          r.status = apct_pkg::STAT_NONE;
          r.slot_a = c.slot;
          r.last = 1'b1;
          found.push_back(r);
        end else begin
          found[found.size() - 1].last = 1'b1;
        end
        foreach (found[k]) expected_reports.push_back(found[k]);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      offering = in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_reports(offered_beat);
        accepted_total++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_beats.size() != 0) begin
          if ($urandom_range(0, 99) < idle_pct) begin
            in_gap = $urandom_range(0, 8);
          end else begin
            offered_beat = pending_beats.pop_front();
            offering = 1'b1;
          end
        end
      end
      in_tvalid <= offering;
      in_tdata <= {offered_beat.listens, offered_beat.kind, offered_beat.h, offered_beat.w,
                   offered_beat.y, offered_beat.x, offered_beat.slot};
      in_tuser <= offered_beat.cmd;
    end
  end

  task automatic check_field(string name, logic [7:0] expv, logic [7:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with nothing expected: status %0d, tdata %h, tlast %b",
                 out_tuser, out_tdata, out_tlast);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", 8'(want.status), 8'(out_tuser));
          check_field("slot_a", 8'(want.slot_a), 8'(out_tdata[4:0]));
          check_field("slot_b", 8'(want.slot_b), 8'(out_tdata[9:5]));
          check_field("notify_a", 8'(want.notify_a), 8'(out_tdata[10]));
          check_field("notify_b", 8'(want.notify_b), 8'(out_tdata[11]));
          check_field("last", 8'(want.last), 8'(out_tlast));
        end
      end
      if (hold_off) begin
        taking = 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        taking = 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_gap = $urandom_range(0, 8);
        taking = 1'b0;
      end else begin
        taking = 1'b1;
      end
      out_tready <= taking;
    end
  end

  function automatic cmd_beat_t make_beat(logic [apct_pkg::CMD_W-1:0] cmd, int slot, int x,
                                          int y, int w, int h, int kind, logic listens);
    cmd_beat_t b;
    b.cmd = cmd;
    b.slot = 5'(slot);
    b.x = 16'(x);
    b.y = 16'(y);
    b.w = 15'(w);
    b.h = 15'(h);
    b.kind = 4'(kind);
    b.listens = listens;
    return b;
  endfunction

  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 42) b.cmd = apct_pkg::CMD_ADD;
    else if (pick < 62) b.cmd = apct_pkg::CMD_REMOVE;
    else if (pick < 96) b.cmd = apct_pkg::CMD_SCAN;
    else b.cmd = CMD_UNUSED;
    b.slot = 5'($urandom_range(0, TABLE_SLOTS - 1));
    if ($urandom_range(0, 7) != 0) begin
      b.x = 16'($urandom_range(0, 600) - 300);
      b.y = 16'($urandom_range(0, 600) - 300);
      b.w = 15'($urandom_range(0, 400));
      b.h = 15'($urandom_range(0, 400));
    end else begin
      b.x = 16'($urandom_range(0, 65535));
      b.y = 16'($urandom_range(0, 65535));
      b.w = 15'($urandom_range(0, 32767));
      b.h = 15'($urandom_range(0, 32767));
    end
    b.kind = 4'($urandom_range(0, 15));
    b.listens = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic void queue_beat(cmd_beat_t b);
    pending_beats.push_back(b);
    issued_total++;
  endfunction

  task automatic write_mask_word(int idx, logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= 2'(idx);
    cfg_wdata <= value;
    mask_words[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_table_idle();
    do @(posedge clk);
    while (accepted_total != issued_total || expected_reports.size() != 0);
    repeat (TABLE_SLOTS + 8) @(posedge clk);
  endtask

  initial begin
    int r, n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Every pair enabled; edges that only touch must not count as overlap.
    for (r = 0; r < apct_pkg::MASK_REGS; r++) write_mask_word(r, '1);
    idle_pct = 25;
    queue_beat(make_beat(apct_pkg::CMD_ADD, 0, -32768, -32768, 32767, 32767, 0, 1'b1));
    queue_beat(make_beat(apct_pkg::CMD_ADD, 31, 32767, 32767, 0, 0, 15, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_ADD, 0, 0, 0, 1, 1, 15, 1'b1));
    queue_beat(make_beat(apct_pkg::CMD_ADD, 0, -1, -1, 1, 1, 5, 1'b1));
    queue_beat(make_beat(apct_pkg::CMD_ADD, 0, -2, -2, 3, 3, 7, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, 0, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, 2, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, 3, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, 1, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, 4, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, 31, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_REMOVE, 1, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_REMOVE, 1, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_REMOVE, 31, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, 1, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(CMD_UNUSED, 31, 32767, -32768, 32767, 32767, 15, 1'b1));
    queue_beat(make_beat(apct_pkg::CMD_ADD, 0, 32767, -32768, 32767, 0, 15, 1'b1));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, 1, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_ADD, 0, -5, -5, 32767, 32767, 9, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, 0, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, 0, 0, 0, 0, 0, 0, 1'b0));
    wait_table_idle();

    // With the mask cleared, every overlap is filtered out.
    for (r = 0; r < apct_pkg::MASK_REGS; r++) write_mask_word(r, '0);
    idle_pct = 20;
    for (n = 0; n < 80; n++) queue_beat(random_beat());
    wait_table_idle();

    for (r = 0; r < apct_pkg::MASK_REGS; r++) write_mask_word(r, {$urandom, $urandom});
    idle_pct = 30;
    for (n = 0; n < 100; n++) queue_beat(random_beat());
    wait_table_idle();

    // Clear the table, then fill it past capacity with colliders that all overlap,
    // so that a scan of the lowest slot reports the largest number of pairs.
    for (r = 0; r < apct_pkg::MASK_REGS; r++) write_mask_word(r, '1);
    idle_pct = 10;
    for (n = 0; n < TABLE_SLOTS; n++) begin
      queue_beat(make_beat(apct_pkg::CMD_REMOVE, n, 0, 0, 0, 0, 0, 1'b0));
    end
    for (n = 0; n < TABLE_SLOTS + 2; n++) begin
      queue_beat(make_beat(apct_pkg::CMD_ADD, 0, $urandom_range(0, 50) - 100,
                           $urandom_range(0, 50) - 100, $urandom_range(200, 32767),
                           $urandom_range(200, 32767), $urandom_range(0, 15),
                           (n == 0) ? 1'b1 : 1'($urandom_range(0, 1))));
    end
    queue_beat(make_beat(apct_pkg::CMD_SCAN, 0, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, TABLE_SLOTS - 2, 0, 0, 0, 0, 0, 1'b0));
    queue_beat(make_beat(apct_pkg::CMD_SCAN, TABLE_SLOTS - 1, 0, 0, 0, 0, 0, 1'b0));
    for (n = 0; n < 40; n++) queue_beat(random_beat());
    wait_table_idle();

    for (r = 0; r < apct_pkg::MASK_REGS; r++) begin
      write_mask_word(r, {$urandom, $urandom} & {$urandom, $urandom});
    end
    idle_pct = 0;
    for (n = 0; n < 80; n++) queue_beat(random_beat());
    wait_table_idle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Long output stall in the middle of the run so the input side backs up.
  initial begin
    do @(posedge clk);
    while (accepted_total < 150);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #6000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/apct_pkg.sv
hw/rtl/apct_slot_mem.sv
hw/rtl/apct_pair_check.sv
hw/rtl/aabb_pair_collision_table.sv
sim/tb_aabb_pair_collision_table.sv
